// File: sv/coalescing_best_fit_allocator_defines.svh
// ---------------------------------------------------------------------------
// coalescing best-fit allocator assertion macros
// shared assertion forms clocked on i_clk, gated by the active-low reset
// ---------------------------------------------------------------------------
`ifndef COALESCING_BEST_FIT_ALLOCATOR_DEFINES_SVH
`define COALESCING_BEST_FIT_ALLOCATOR_DEFINES_SVH

// property holds at every edge outside reset
`define CBFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CBFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cbfa_pkg.sv
// ---------------------------------------------------------------------------
// cbfa_pkg
// codes and reset constants of the coalescing best-fit allocator
// ---------------------------------------------------------------------------
package cbfa_pkg;

    localparam int MAX_SLOTS_DEF       = 1024;
    localparam int MAX_FREE_BLOCKS_DEF = 512;
    localparam int STALE_DEPTH_DEF     = 64;

    localparam int HEAP_SIZE_RESET = 1024;
    localparam int STRIDE_RESET    = 32;
    localparam int STRIDE_W        = 13;
    localparam int ADDR_W          = 64;
    localparam int CFG_ADDR_W      = 5;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_NOFIT = 2'd1,
        STS_FULL  = 2'd2,
        STS_ZERO  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_HEAP_SIZE = 2'd0,
        REG_BASE_ADDR = 2'd1,
        REG_STRIDE    = 2'd2
    } t_reg_idx;

endpackage

// File: sv/coalescing_best_fit_allocator.sv
// ---------------------------------------------------------------------------
// coalescing_best_fit_allocator
// best-fit slot allocator over a sorted free-block memory, with a queue of
// freed ranges that a release command merges back into the table
// ---------------------------------------------------------------------------
// One command is in flight at a time: busy is high from the accepting edge
// until the cycle before o_done pulses. Every command produces exactly one
// result, shown for one cycle with o_done; the receiver cannot stall it.
// Steps per command (E = free blocks in the table, Q = queued frees):
//   allocate: a best-fit scan (one table read per cycle), a multiply and add
//   for the address, plus, when a block is used up, a shift of the entries
//   above it down to close the gap in the table.
//   free: the bit-serial divide of the handle offset by the stride
//   (one quotient bit per cycle over 64 bits), then a range check.
//   release: per queued range, a queue read, a scan of the table up to the
//   insertion point and, when the range stands alone or joins two blocks, a
//   shift of up to E entries of the table tail; zero-count commands go
//   straight to the finish state.
// All table traffic goes through a single memory port pair (one read, one
// write each cycle), which paces the scans and shifts. After reset the block
// stays busy in its init state while table entry zero is written.
// ---------------------------------------------------------------------------
`include "coalescing_best_fit_allocator_defines.svh"

module coalescing_best_fit_allocator #(
    parameter int MAX_SLOTS       = cbfa_pkg::MAX_SLOTS_DEF,
    parameter int MAX_FREE_BLOCKS = cbfa_pkg::MAX_FREE_BLOCKS_DEF,
    parameter int STALE_DEPTH     = cbfa_pkg::STALE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command transfer
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]      i_slot_count,
    input  logic [cbfa_pkg::ADDR_W-1:0]         i_handle_in,
    // result transfer
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [cbfa_pkg::ADDR_W-1:0]         o_handle_out,
    output logic [$clog2(MAX_SLOTS+1)-1:0]      o_free_total,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbfa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [cbfa_pkg::ADDR_W-1:0]         pwdata,
    output logic [cbfa_pkg::ADDR_W-1:0]         prdata,
    output logic                                pready
);
    import cbfa_pkg::*;

    // slot index and slot count widths
    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int LW  = $clog2(MAX_SLOTS + 1);
    // table index and fill count widths
    localparam int TIW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
    localparam int EW  = $clog2(MAX_FREE_BLOCKS + 1);
    // queue index and fill count widths
    localparam int QIW = (STALE_DEPTH > 1) ? $clog2(STALE_DEPTH) : 1;
    localparam int QW  = $clog2(STALE_DEPTH + 1);
    localparam int PW  = SW + STRIDE_W;
    localparam int HEAP_RESET_CL =
        (HEAP_SIZE_RESET > MAX_SLOTS) ? MAX_SLOTS : HEAP_SIZE_RESET;

    typedef struct packed {
        logic [SW-1:0] start;
        logic [LW-1:0] len;
    } t_blk;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_A_SCAN, ST_A_MUL, ST_A_UPD, ST_RM,
        ST_F_DIV, ST_F_CHK, ST_R_QRD, ST_R_QDAT, ST_R_SCAN, ST_R_DEC,
        ST_INS, ST_R_NEXT, ST_FIN
    } t_state;

    // configuration
    logic [LW-1:0]       r_heap;
    logic [ADDR_W-1:0]   r_base;
    logic [STRIDE_W-1:0] r_stride;
    logic [STRIDE_W-1:0] stride_eff;

    // allocator state
    t_state          r_state;
    logic [EW-1:0]   r_entries;
    logic [LW-1:0]   r_free;
    logic [QW-1:0]   r_stale_used;

    // command registers
    logic [LW-1:0]     r_count;
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_hout;
    logic [LW-1:0]     r_out_free;
    logic              r_done;
    logic              r_in_rel;

    // scan pipeline
    logic [EW-1:0]  r_k;
    logic           r_vld_d;
    logic [TIW-1:0] r_idx_d;

    // best fit
    logic           r_found;
    logic [TIW-1:0] r_best_idx;
    logic [SW-1:0]  r_best_start;
    logic [LW-1:0]  r_best_len;
    logic [PW-1:0]  r_prod;

    // divider
    logic [ADDR_W-1:0]   r_quo;
    logic [STRIDE_W-1:0] r_rem;
    logic [5:0]          r_cnt;
    logic [STRIDE_W:0]   rem2;
    logic                div_ge;

    // release
    logic [QW-1:0]  r_q;
    logic [SW-1:0]  r_off;
    logic [LW-1:0]  r_len;
    logic           r_prev_v;
    logic [TIW-1:0] r_prev_idx;
    logic [SW-1:0]  r_prev_start;
    logic [LW-1:0]  r_prev_len;
    logic           r_next_v;
    logic [SW-1:0]  r_next_start;
    logic [LW-1:0]  r_next_len;
    logic [EW-1:0]  r_ins;

    // memories
    t_blk           tbl_mem [MAX_FREE_BLOCKS];
    t_blk           tbl_rd;
    logic [TIW-1:0] tbl_raddr;
    logic           tbl_we;
    logic [TIW-1:0] tbl_waddr;
    t_blk           tbl_wdata;

    t_blk           stale_mem [STALE_DEPTH];
    t_blk           stale_rd;
    logic           stale_we;

    // decode helpers
    logic            cfg_wr;
    logic [1:0]      cfg_idx;
    logic [LW-1:0]   heap_wr;
    logic            scan_more;
    logic            ins_more;
    logic [LW:0]     prev_end;
    logic [LW:0]     off_end;
    logic            drop;
    logic            prev_adj;
    logic            next_adj;
    logic [LW:0]     free_sum;
    logic            in_range;
    logic            rq_bad;

    assign stride_eff = (r_stride == '0) ? STRIDE_W'(1) : r_stride;
    assign cfg_wr     = psel && penable && pwrite;
    assign cfg_idx    = paddr[4:3];
    assign pready     = 1'b1;

    // heap size writes are clamped into 1..MAX_SLOTS
    always_comb begin
        heap_wr = pwdata[LW-1:0];
        if (heap_wr == '0) begin
            heap_wr = LW'(1);
        end else if (heap_wr > LW'(MAX_SLOTS)) begin
            heap_wr = LW'(MAX_SLOTS);
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HEAP_SIZE: prdata = ADDR_W'(r_heap);
            REG_BASE_ADDR: prdata = r_base;
            REG_STRIDE:    prdata = ADDR_W'(r_stride);
            default:       prdata = '0;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    assign scan_more = (r_k < r_entries);
    assign ins_more  = (r_k > r_ins);

    // restoring divide step, one quotient bit per cycle
    assign rem2   = {r_rem, r_quo[ADDR_W-1]};
    assign div_ge = (rem2 >= {1'b0, stride_eff});

    // freed range fits inside the heap
    assign in_range = (r_quo < ADDR_W'(r_heap)) &&
                      (r_count <= (r_heap - r_quo[LW-1:0]));

    // queued range no longer inside the heap
    assign rq_bad = (stale_rd.len == '0) || (LW'(stale_rd.start) >= r_heap) ||
                    (stale_rd.len > (r_heap - LW'(stale_rd.start)));

    // neighbor tests for the merge
    assign prev_end = (LW+1)'(r_prev_start) + (LW+1)'(r_prev_len);
    assign off_end  = (LW+1)'(r_off) + (LW+1)'(r_len);
    assign drop     = (r_prev_v && (prev_end > (LW+1)'(r_off))) ||
                      (r_next_v && ((LW+1)'(r_next_start) < off_end));
    assign prev_adj = r_prev_v && (prev_end == (LW+1)'(r_off));
    assign next_adj = r_next_v && ((LW+1)'(r_next_start) == off_end);
    assign free_sum = (LW+1)'(r_free) + (LW+1)'(r_len);

    // table port control
    always_comb begin
        tbl_raddr = r_k[TIW-1:0];
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        case (r_state)
            ST_INIT: begin
                tbl_we         = 1'b1;
                tbl_wdata.len  = r_heap;
            end
            ST_A_UPD: begin
                if (r_best_len != r_count) begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = r_best_idx;
                    tbl_wdata.start = r_best_start + SW'(r_count);
                    tbl_wdata.len   = r_best_len - r_count;
                end
            end
            ST_RM: begin
                if (r_vld_d) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_idx_d - TIW'(1);
                    tbl_wdata = tbl_rd;
                end
            end
            ST_R_DEC: begin
                if (!drop && prev_adj) begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = r_prev_idx;
                    tbl_wdata.start = r_prev_start;
                    tbl_wdata.len   = next_adj ? LW'(r_prev_len + r_len + r_next_len)
                                               : LW'(r_prev_len + r_len);
                end else if (!drop && next_adj) begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = r_ins[TIW-1:0];
                    tbl_wdata.start = r_off;
                    tbl_wdata.len   = LW'(r_next_len + r_len);
                end
            end
            ST_INS: begin
                tbl_raddr = TIW'(r_k - EW'(1));
                if (r_vld_d) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_idx_d;
                    tbl_wdata = tbl_rd;
                end else if (!ins_more) begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = r_ins[TIW-1:0];
                    tbl_wdata.start = r_off;
                    tbl_wdata.len   = r_len;
                end
            end
            default: begin
            end
        endcase
        // heap size write reseeds entry zero; the user must write it only while idle, the block does not enforce this
        if (cfg_wr && (cfg_idx == REG_HEAP_SIZE)) begin
            tbl_we          = 1'b1;
            tbl_waddr       = '0;
            tbl_wdata.start = '0;
            tbl_wdata.len   = heap_wr;
        end
    end

    assign stale_we = (r_state == ST_F_CHK) && in_range &&
                      (r_stale_used < QW'(STALE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stale_we) begin
            stale_mem[r_stale_used[QIW-1:0]] <= '{start: r_quo[SW-1:0], len: r_count};
        end
        stale_rd <= stale_mem[r_q[QIW-1:0]];
    end

    // control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_heap       <= LW'(HEAP_RESET_CL);
            r_base       <= '0;
            r_stride     <= STRIDE_W'(STRIDE_RESET);
            r_entries    <= EW'(1);
            r_free       <= LW'(HEAP_RESET_CL);
            r_stale_used <= '0;
            r_done       <= 1'b0;
            r_vld_d      <= 1'b0;
        end else begin
            r_done <= 1'b0;

            if (cfg_wr) begin
                case (cfg_idx)
                    REG_HEAP_SIZE: begin
                        r_heap       <= heap_wr;
                        r_free       <= heap_wr;
                        r_entries    <= EW'(1);
                        r_stale_used <= '0;
                    end
                    REG_BASE_ADDR: r_base   <= pwdata;
                    REG_STRIDE:    r_stride <= pwdata[STRIDE_W-1:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_INIT: r_state <= ST_IDLE;

                ST_IDLE: begin
                    if (start) begin
                        r_count  <= i_slot_count;
                        r_status <= STS_OK;
                        r_hout   <= '0;
                        r_k      <= '0;
                        r_vld_d  <= 1'b0;
                        r_found  <= 1'b0;
                        r_q      <= '0;
                        r_in_rel <= 1'b0;
                        case (i_action)
                            ACT_ALLOC: begin
                                if (i_slot_count == '0) begin
                                    r_status <= STS_ZERO;
                                    r_state  <= ST_FIN;
                                end else if (i_slot_count > r_free) begin
                                    r_status <= STS_NOFIT;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_state <= ST_A_SCAN;
                                end
                            end
                            ACT_FREE: begin
                                if (i_slot_count == '0) begin
                                    r_status <= STS_ZERO;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_quo   <= i_handle_in - r_base;
                                    r_rem   <= '0;
                                    r_cnt   <= '0;
                                    r_state <= ST_F_DIV;
                                end
                            end
                            ACT_RELEASE: begin
                                r_in_rel <= 1'b1;
                                r_state  <= (r_stale_used == '0) ? ST_FIN : ST_R_QRD;
                            end
                            default: r_state <= ST_FIN;
                        endcase
                    end
                end

                // best fit scan, one entry per cycle, strict less keeps lowest start
                ST_A_SCAN: begin
                    if (scan_more) begin
                        r_k     <= r_k + EW'(1);
                        r_vld_d <= 1'b1;
                        r_idx_d <= r_k[TIW-1:0];
                    end else begin
                        r_vld_d <= 1'b0;
                    end
                    if (r_vld_d && (tbl_rd.len >= r_count) &&
                        (!r_found || (tbl_rd.len < r_best_len))) begin
                        r_found      <= 1'b1;
                        r_best_idx   <= r_idx_d;
                        r_best_start <= tbl_rd.start;
                        r_best_len   <= tbl_rd.len;
                    end
                    if (!scan_more && !r_vld_d) begin
                        if (r_found) begin
                            r_state <= ST_A_MUL;
                        end else begin
                            r_status <= STS_NOFIT;
                            r_state  <= ST_FIN;
                        end
                    end
                end

                ST_A_MUL: begin
                    r_prod  <= PW'(r_best_start) * PW'(stride_eff);
                    r_state <= ST_A_UPD;
                end

                ST_A_UPD: begin
                    r_hout <= r_base + ADDR_W'(r_prod);
                    r_free <= r_free - r_count;
                    if (r_best_len == r_count) begin
                        r_k     <= EW'(r_best_idx) + EW'(1);
                        r_vld_d <= 1'b0;
                        r_state <= ST_RM;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end

                // close the gap: move entries above the removed one down by one
                ST_RM: begin
                    if (scan_more) begin
                        r_k     <= r_k + EW'(1);
                        r_vld_d <= 1'b1;
                        r_idx_d <= r_k[TIW-1:0];
                    end else begin
                        r_vld_d <= 1'b0;
                        if (!r_vld_d) begin
                            r_entries <= r_entries - EW'(1);
                            r_state   <= r_in_rel ? ST_R_NEXT : ST_FIN;
                        end
                    end
                end

                ST_F_DIV: begin
                    r_rem <= div_ge ? STRIDE_W'(rem2 - {1'b0, stride_eff})
                                    : rem2[STRIDE_W-1:0];
                    r_quo <= {r_quo[ADDR_W-2:0], div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= ST_F_CHK;
                    end
                end

                // out-of-heap frees are dropped silently
                ST_F_CHK: begin
                    if (in_range) begin
                        if (r_stale_used < QW'(STALE_DEPTH)) begin
                            r_stale_used <= r_stale_used + QW'(1);
                        end else begin
                            r_status <= STS_FULL;
                        end
                    end
                    r_state <= ST_FIN;
                end

                ST_R_QRD: r_state <= ST_R_QDAT;

                ST_R_QDAT: begin
                    r_off    <= stale_rd.start;
                    r_len    <= stale_rd.len;
                    r_k      <= '0;
                    r_vld_d  <= 1'b0;
                    r_prev_v <= 1'b0;
                    r_next_v <= 1'b0;
                    r_state  <= rq_bad ? ST_R_NEXT : ST_R_SCAN;
                end

                // find the first block at or above the freed start
                ST_R_SCAN: begin
                    if (r_vld_d && (tbl_rd.start >= r_off)) begin
                        r_next_v     <= 1'b1;
                        r_next_start <= tbl_rd.start;
                        r_next_len   <= tbl_rd.len;
                        r_ins        <= EW'(r_idx_d);
                        r_vld_d      <= 1'b0;
                        r_state      <= ST_R_DEC;
                    end else begin
                        if (r_vld_d) begin
                            r_prev_v     <= 1'b1;
                            r_prev_idx   <= r_idx_d;
                            r_prev_start <= tbl_rd.start;
                            r_prev_len   <= tbl_rd.len;
                        end
                        if (scan_more) begin
                            r_k     <= r_k + EW'(1);
                            r_vld_d <= 1'b1;
                            r_idx_d <= r_k[TIW-1:0];
                        end else begin
                            r_vld_d <= 1'b0;
                            if (!r_vld_d) begin
                                r_ins   <= r_entries;
                                r_state <= ST_R_DEC;
                            end
                        end
                    end
                end

                // merge decision; double frees and table overflow drop the range
                ST_R_DEC: begin
                    if (drop) begin
                        r_state <= ST_R_NEXT;
                    end else if (!prev_adj && !next_adj &&
                                 (r_entries >= EW'(MAX_FREE_BLOCKS))) begin
                        r_state <= ST_R_NEXT;
                    end else begin
                        r_free <= (free_sum > (LW+1)'(r_heap)) ? r_heap : LW'(free_sum);
                        if (prev_adj && next_adj) begin
                            r_k     <= r_ins + EW'(1);
                            r_vld_d <= 1'b0;
                            r_state <= ST_RM;
                        end else if (prev_adj || next_adj) begin
                            r_state <= ST_R_NEXT;
                        end else begin
                            r_k     <= r_entries;
                            r_vld_d <= 1'b0;
                            r_state <= ST_INS;
                        end
                    end
                end

                // open a gap: move entries at and above the insert point up by one
                ST_INS: begin
                    if (ins_more) begin
                        r_k     <= r_k - EW'(1);
                        r_vld_d <= 1'b1;
                        r_idx_d <= r_k[TIW-1:0];
                    end else begin
                        r_vld_d <= 1'b0;
                        if (!r_vld_d) begin
                            r_entries <= r_entries + EW'(1);
                            r_state   <= ST_R_NEXT;
                        end
                    end
                end

                ST_R_NEXT: begin
                    if ((r_q + QW'(1)) >= r_stale_used) begin
                        r_stale_used <= '0;
                        r_state      <= ST_FIN;
                    end else begin
                        r_q     <= r_q + QW'(1);
                        r_state <= ST_R_QRD;
                    end
                end

                ST_FIN: begin
                    r_done     <= 1'b1;
                    r_out_free <= r_free;
                    r_state    <= ST_IDLE;
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_handle_out = r_hout;
    assign o_free_total = r_out_free;

    `CBFA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted command left block idle")
    `CBFA_ASSERT_NEXT(a_fin_gives_done, r_state == ST_FIN, o_done, "finish without result strobe")
    `CBFA_ASSERT(a_free_in_heap, r_free <= r_heap, "free slot count exceeds heap size")
    `CBFA_ASSERT(a_table_bound, r_entries <= EW'(MAX_FREE_BLOCKS), "free table overflow")

endmodule

// File: verif/coalescing_best_fit_allocator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coalescing_best_fit_allocator_tb
// self-checking bench: a directed table of commands, a stale queue overflow run,
// then random allocate / free / release traffic over several register settings;
// every result transfer is compared field by field with a typed row or the in-bench allocator model
// ---------------------------------------------------------------------------
module coalescing_best_fit_allocator_tb;
    import cbfa_pkg::*;

    localparam int          CNT_W      = 11;
    localparam int          WDOG_LIMIT = 400000;
    localparam int          N_PHASES   = 5;
    localparam int          RAND_ITEMS = 140;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    // dut ports
    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_action;
    logic [CNT_W-1:0]  i_slot_count;
    logic [63:0]       i_handle_in;
    logic              o_done;
    logic [1:0]        o_status;
    logic [63:0]       o_handle_out;
    logic [CNT_W-1:0]  o_free_total;
    logic              psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    coalescing_best_fit_allocator dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // allocator model: free-block table sorted by start, plus stale queue
    // ------------------------------------------------------------------
    int unsigned    heap_slots;
    logic [63:0]    slot0_addr;
    logic [12:0]    stride_reg;
    int unsigned    blk_start [MAX_FREE_BLOCKS_DEF];
    int unsigned    blk_len   [MAX_FREE_BLOCKS_DEF];
    int unsigned    blk_count;
    int unsigned    free_slots;
    int unsigned    pend_start [STALE_DEPTH_DEF];
    int unsigned    pend_len   [STALE_DEPTH_DEF];
    int unsigned    pend_count;

    typedef struct {
        logic [1:0]       status;
        logic [63:0]      handle;
        logic [CNT_W-1:0] free_total;
    } alloc_result_t;

    alloc_result_t expected_results[$];

    // live allocations, used to build well-formed frees
    logic [63:0] live_handle[$];
    int unsigned live_count[$];

    int errors, items_sent, results_seen, idle_pct, wdog;

    function automatic logic [63:0] stride_eff();
        return (stride_reg == 0) ? 64'd1 : 64'(stride_reg);
    endfunction

    function automatic void restore_table();
        blk_count    = 1;
        blk_start[0] = 0;
        blk_len[0]   = heap_slots;
        free_slots   = heap_slots;
        pend_count   = 0;
    endfunction

    function automatic void drop_block(int unsigned idx);
        for (int unsigned k = idx; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_len[k]   = blk_len[k+1];
        end
        blk_count--;
    endfunction

    // merge one released range back into the table
    function automatic void merge_range(int unsigned off, int unsigned len);
        int unsigned i;
        bit prev_adj, next_adj;
        i = 0;
        if (len == 0 || off >= heap_slots || len > heap_slots - off) return;
        while (i < blk_count && blk_start[i] < off) i++;
        // overlap with a block already free: double free, drop it
        if (i > 0 && blk_start[i-1] + blk_len[i-1] > off) return;
        if (i < blk_count && blk_start[i] < off + len) return;
        prev_adj = (i > 0) && (blk_start[i-1] + blk_len[i-1] == off);
        next_adj = (i < blk_count) && (blk_start[i] == off + len);
        if (prev_adj && next_adj) begin
            blk_len[i-1] += len + blk_len[i];
            drop_block(i);
        end else if (prev_adj) begin
            blk_len[i-1] += len;
        end else if (next_adj) begin
            blk_start[i] = off;
            blk_len[i]  += len;
        end else begin
            if (blk_count >= MAX_FREE_BLOCKS_DEF) return;
            for (int unsigned k = blk_count; k > i; k--) begin
                blk_start[k] = blk_start[k-1];
                blk_len[k]   = blk_len[k-1];
            end
            blk_start[i] = off;
            blk_len[i]   = len;
            blk_count++;
        end
        free_slots += len;
        if (free_slots > heap_slots) free_slots = heap_slots;
    endfunction

    function automatic alloc_result_t run_command(logic [1:0] act, int unsigned cnt,
                                                  logic [63:0] hin);
        alloc_result_t r;
        int unsigned best;
        logic [63:0] off;
        r.status = STS_OK;
        r.handle = '0;
        if (act == ACT_ALLOC) begin
            if (cnt == 0) begin
                r.status = STS_ZERO;
            end else if (cnt > free_slots) begin
                r.status = STS_NOFIT;
            end else begin
                best = blk_count;
                for (int unsigned i = 0; i < blk_count; i++)
                    if (blk_len[i] >= cnt && (best == blk_count || blk_len[i] < blk_len[best]))
                        best = i;
                if (best == blk_count) begin
                    r.status = STS_NOFIT;
                end else begin
                    r.handle = slot0_addr + 64'(blk_start[best]) * stride_eff();
                    if (blk_len[best] == cnt) begin
                        drop_block(best);
                    end else begin
                        blk_start[best] += cnt;
                        blk_len[best]   -= cnt;
                    end
                    free_slots -= cnt;
                end
            end
        end else if (act == ACT_FREE) begin
            if (cnt == 0) begin
                r.status = STS_ZERO;
            end else begin
                off = (hin - slot0_addr) / stride_eff();
                // ranges outside the heap are dropped silently
                if (off < 64'(heap_slots) && 64'(cnt) <= 64'(heap_slots) - off) begin
                    if (pend_count >= STALE_DEPTH_DEF) begin
                        r.status = STS_FULL;
                    end else begin
                        pend_start[pend_count] = int'(off);
                        pend_len[pend_count]   = cnt;
                        pend_count++;
                    end
                end
            end
        end else if (act == ACT_RELEASE) begin
            for (int unsigned i = 0; i < pend_count; i++)
                merge_range(pend_start[i], pend_len[i]);
            pend_count = 0;
        end
        r.free_total = CNT_W'(free_slots);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got 0x%0h expected 0x%0h (result %0d)",
                 what, got, want, results_seen);
    endtask

    always @(posedge i_clk) begin
        alloc_result_t want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_status, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_handle_out !== want.handle)
                    report_mismatch("handle_out", o_handle_out, want.handle);
                if (o_free_total !== want.free_total)
                    report_mismatch("free_total", o_free_total, want.free_total);
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_LIMIT) begin
                $display("watchdog expired");
                $display("[coalescing_best_fit_allocator] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers (inputs change at the falling edge)
    // ------------------------------------------------------------------
    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = CFG_ADDR_W'(8 * int'(idx)); pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_HEAP_SIZE: begin
                heap_slots = value[10:0];
                if (heap_slots < 1) heap_slots = 1;
                if (heap_slots > MAX_SLOTS_DEF) heap_slots = MAX_SLOTS_DEF;
                restore_table();
                live_handle.delete();
                live_count.delete();
            end
            REG_BASE_ADDR: slot0_addr = value;
            default:       stride_reg = value[12:0];
        endcase
    endtask

    // one command transfer; a typed expectation replaces the predicted one
    task automatic send_command(logic [1:0] act, int unsigned cnt, logic [63:0] hin,
                                bit typed, alloc_result_t typed_res);
        alloc_result_t r;
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_action = act;
        i_slot_count = CNT_W'(cnt);
        i_handle_in = hin;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);   // transfer at the rising edge in between
        start = 1'b0;
        items_sent++;
        r = run_command(act, cnt, hin);
        if (act == ACT_ALLOC && r.status == STS_OK) begin
            live_handle.push_back(r.handle);
            live_count.push_back(cnt);
        end
        expected_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // directed table, run right after reset (heap 1024, base 0, stride 32)
    // ------------------------------------------------------------------
    typedef struct {
        logic [1:0]       act;
        int unsigned      cnt;
        logic [63:0]      hin;
        bit               typed;
        logic [1:0]       st;
        logic [63:0]      hout;
        int unsigned      ftot;
    } cmd_row_t;

    cmd_row_t dir_rows[] = '{
        '{ACT_ALLOC,   0,    64'd0,     1, STS_ZERO,  64'd0,  1024},  // zero count
        '{ACT_FREE,    0,    64'd0,     1, STS_ZERO,  64'd0,  1024},
        '{ACT_ALLOC,   1025, 64'd0,     1, STS_NOFIT, 64'd0,  1024},  // too large
        '{ACT_ALLOC,   2047, 64'd0,     1, STS_NOFIT, 64'd0,  1024},
        '{ACT_ALLOC,   1024, 64'd0,     1, STS_OK,    64'd0,  0},     // whole heap
        '{ACT_ALLOC,   1,    64'd0,     1, STS_NOFIT, 64'd0,  0},
        '{ACT_FREE,    1024, 64'd0,     1, STS_OK,    64'd0,  0},
        '{ACT_UNUSED,  5,    ALL_ONES,  1, STS_OK,    64'd0,  0},     // unused action
        '{ACT_RELEASE, 0,    64'd0,     1, STS_OK,    64'd0,  1024},
        '{ACT_ALLOC,   1,    64'd0,     1, STS_OK,    64'd0,  1023},
        '{ACT_ALLOC,   3,    64'd0,     1, STS_OK,    64'd32, 1020},
        '{ACT_ALLOC,   2,    64'd0,     0, 0, 0, 0},
        '{ACT_FREE,    3,    64'd45,    0, 0, 0, 0},  // handle inside a slot truncates
        '{ACT_FREE,    1,    ALL_ONES,  0, 0, 0, 0},  // top of the address space, far outside the heap
        '{ACT_FREE,    2,    64'd32736, 0, 0, 0, 0},  // runs past the heap end
        '{ACT_RELEASE, 0,    64'd0,     0, 0, 0, 0},
        '{ACT_FREE,    1,    64'd0,     0, 0, 0, 0},
        '{ACT_FREE,    1,    64'd0,     0, 0, 0, 0},  // double free
        '{ACT_FREE,    2,    64'd128,   0, 0, 0, 0},
        '{ACT_RELEASE, 0,    64'd0,     0, 0, 0, 0},
        '{ACT_ALLOC,   1,    64'd0,     0, 0, 0, 0},
        '{ACT_ALLOC,   1020, 64'd0,     0, 0, 0, 0}
    };

    // ------------------------------------------------------------------
    // random command: allocations and frees of live allocations, some noise
    // ------------------------------------------------------------------
    task automatic random_command();
        int unsigned sel, idx, cnt;
        logic [63:0] hin;
        alloc_result_t none;
        sel = $urandom_range(99);
        none = '{default: '0};
        if (sel < 42) begin
            if ($urandom_range(9) == 0) cnt = $urandom_range(2047);
            else if ($urandom_range(19) == 0) cnt = 0;
            else cnt = $urandom_range(1, heap_slots / 6 + 1);
            send_command(ACT_ALLOC, cnt, 64'd0, 0, none);
        end else if (sel < 80 && live_handle.size() != 0) begin
            idx = $urandom_range(live_handle.size() - 1);
            hin = live_handle[idx] + 64'($urandom_range(int'(stride_eff()) - 1));
            cnt = live_count[idx];
            if ($urandom_range(9) != 0) begin
                live_handle.delete(idx);
                live_count.delete(idx);
            end
            send_command(ACT_FREE, cnt, hin, 0, none);
        end else if (sel < 86) begin
            hin = {$urandom, $urandom};
            send_command(ACT_FREE, $urandom_range(2047), hin, 0, none);
        end else if (sel < 97) begin
            send_command(ACT_RELEASE, $urandom_range(2047), {$urandom, $urandom}, 0, none);
        end else begin
            send_command(ACT_UNUSED, $urandom_range(2047), {$urandom, $urandom}, 0, none);
        end
    endtask

    // register settings per phase; extremes first
    logic [63:0] phase_heap[N_PHASES]   = '{64'd2047, 64'd0, 64'd16, 64'd3, 64'd1024};
    logic [63:0] phase_base[N_PHASES]   = '{64'd0, ALL_ONES, 64'h8000_0000_0000_0000,
                                            64'd4096, 64'h0000_00FF_F000_0000};
    logic [63:0] phase_stride[N_PHASES] = '{64'd8191, 64'd0, 64'd1, 64'd4096, 64'd32};
    int          phase_idle[N_PHASES]   = '{0, 55, 16, 55, 0};

    initial begin
        alloc_result_t typed_res;
        errors = 0; items_sent = 0; results_seen = 0; idle_pct = 0;
        i_rst_n = 1'b0; start = 1'b0;
        i_action = ACT_ALLOC; i_slot_count = '0; i_handle_in = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        heap_slots = HEAP_SIZE_RESET; slot0_addr = '0; stride_reg = STRIDE_RESET;
        restore_table();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (dir_rows[n]) begin
            typed_res.status     = dir_rows[n].st;
            typed_res.handle     = dir_rows[n].hout;
            typed_res.free_total = CNT_W'(dir_rows[n].ftot);
            send_command(dir_rows[n].act, dir_rows[n].cnt, dir_rows[n].hin,
                         dir_rows[n].typed, typed_res);
        end
        // hold off until every result is back
        drain_results();

        // stale queue overflow: two more frees than the queue holds
        for (int n = 0; n < STALE_DEPTH_DEF + 2; n++)
            send_command(ACT_FREE, 1, 64'(n % 4) * 64'd32, 0, typed_res);
        send_command(ACT_RELEASE, 0, 64'd0, 0, typed_res);
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(REG_HEAP_SIZE, phase_heap[p]);
            write_reg(REG_BASE_ADDR, phase_base[p]);
            write_reg(REG_STRIDE, phase_stride[p]);
            idle_pct = phase_idle[p];
            for (int n = 0; n < RAND_ITEMS; n++) random_command();
            idle_pct = 0;
            drain_results();
        end

        $display("covered %0d phases of register settings, %0d commands, %0d results checked",
                 N_PHASES, items_sent, results_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[coalescing_best_fit_allocator] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_results.size());
            $display("[coalescing_best_fit_allocator] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/cbfa_pkg.sv
sv/coalescing_best_fit_allocator.sv
verif/coalescing_best_fit_allocator_tb.sv
